// File: src/assert_macros.svh
// Assertion helpers used by hip_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/hip_pkg.sv
package hip_pkg;

	// field widths
	localparam int POS_W      = 64;
	localparam int AXIS_W     = 3;
	localparam int COORD_W    = 18;
	localparam int COORD_FRAC = 17;
	localparam int DIMS_W     = 4;
	localparam int LEVELS_W   = 5;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 1;

	// accumulator resolution is 2^-ACC_FRAC, plus sign and headroom
	localparam int ACC_FRAC = 34;
	localparam int ACC_W    = ACC_FRAC + 2;

	// register reset values
	localparam logic [DIMS_W-1:0]   DIMS_RESET   = DIMS_W'(2);
	localparam logic [LEVELS_W-1:0] LEVELS_RESET = LEVELS_W'(10);

	// parameter defaults
	localparam int DEF_MAX_DIMS   = 8;
	localparam int DEF_MAX_LEVELS = 16;

	// 0.5 in output units
	localparam logic [COORD_W-1:0] HALF_CODE = COORD_W'(1 << (COORD_FRAC - 1));

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIMS   = 1'b0,
		CFG_LEVELS = 1'b1
	} cfg_idx_t;

	// handoff from the level engine to the output stage
	typedef struct packed {
		logic               valid;
		logic               single;
		logic [COORD_W-1:0] direct;
	} hip_ho_t;

endpackage

// File: src/hip_ifs.sv
// input channel: one curve position per item
interface hip_in_if import hip_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             position_is_one;

	modport source (output valid, output position, output position_is_one, input ready);
	modport sink   (input valid, input position, input position_is_one, output ready);
endinterface

// output channel: one coordinate per item
interface hip_out_if import hip_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [AXIS_W-1:0]         axis;
	logic signed [COORD_W-1:0] coord;
	logic                      last;

	modport source (output valid, output axis, output coord, output last, input ready);
	modport sink   (input valid, input axis, input coord, input last, output ready);
endinterface

// File: src/hip_core.sv
// Level engine: takes one dims-bit digit per cycle off the top of the
// fraction shift register and records one sign bit per axis per level.
module hip_core import hip_pkg::*; #(
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	hip_in_if.sink                                 pos_ch,
	input  logic [DIMS_W-1:0]                      dims,
	input  logic [LEVELS_W-1:0]                    levels,
	output hip_ho_t                                ho,
	input  logic                                   ho_ready,
	output logic [$clog2(MAX_DIMS+1)-1:0]          n_out,
	output logic [$clog2(MAX_LEVELS+1)-1:0]        m_out,
	output logic [MAX_DIMS-1:0][MAX_LEVELS-1:0]    signs_out
);

	localparam int NW  = $clog2(MAX_DIMS + 1);
	localparam int MW  = $clog2(MAX_LEVELS + 1);
	localparam int AXW = $clog2(MAX_DIMS);
	localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam logic [LW-1:0] TOP_BIT = LW'(MAX_LEVELS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} core_st_t;

	core_st_t                              state_q;
	logic [POS_W-1:0]                      frac_q;
	logic                                  one_q;
	logic [NW-1:0]                         n_q;
	logic [MW-1:0]                         m_q;
	logic [LW-1:0]                         j_q;
	logic [AXW-1:0]                        it_q;
	logic [MAX_DIMS-1:0]                   wn_q;
	logic [MAX_DIMS-1:0][MAX_LEVELS-1:0]   signs_q;
	logic [COORD_W-1:0]                    direct_q;

	logic                                  accept;
	logic [NW-1:0]                         n_sat;
	logic [MW-1:0]                         m_sat;
	logic                                  last_lvl;
	logic [COORD_W-1:0]                    direct_d;
	logic [POS_W+MAX_DIMS-1:0]             ext;
	logic [POS_W-1:0]                      frac_nxt;

	// digit decode signals, bit set means the node sign is negative
	logic [MAX_DIMS-1:0]                   b, un, vn, us, vs, d, wn_nxt;
	logic [AXW-1:0]                        nm1, lf, l_raw, l_adj;
	logic                                  blast, found;

	assign accept = pos_ch.valid && pos_ch.ready;
	assign pos_ch.ready = (state_q == ST_IDLE);

	// clamp the configured sizes
	always_comb begin
		if (dims == '0)
			n_sat = NW'(1);
		else if (32'(dims) > MAX_DIMS)
			n_sat = NW'(MAX_DIMS);
		else
			n_sat = NW'(dims);
		if (32'(levels) > MAX_LEVELS)
			m_sat = MW'(MAX_LEVELS);
		else
			m_sat = MW'(levels);
	end

	// one-dimensional result: position - 0.5, rounded half up
	always_comb begin
		if (pos_ch.position_is_one)
			direct_d = HALF_CODE;
		else
			direct_d = COORD_W'({1'b0, pos_ch.position[POS_W-1 -: COORD_FRAC]})
				+ COORD_W'(pos_ch.position[POS_W-1-COORD_FRAC]) - HALF_CODE;
	end

	assign last_lvl = (MW'(j_q) == m_q - MW'(1));

	// fraction advances by one digit; an exact one keeps feeding ones
	always_comb begin
		ext = {frac_q, {MAX_DIMS{one_q}}} << n_q;
		frac_nxt = ext[POS_W+MAX_DIMS-1:MAX_DIMS];
	end

	// node signs, exit index and orientation update for one level
	always_comb begin
		nm1 = AXW'(n_q - NW'(1));
		for (int i = 0; i < MAX_DIMS; i++)
			b[i] = frac_q[POS_W-1-i];
		un[0] = ~b[0];
		for (int i = 1; i < MAX_DIMS; i++)
			un[i] = ~(b[i] ^ b[i-1]);
		blast = b[nm1];

		// exit index sits just above the trailing run of equal digit bits
		found = 1'b0;
		lf = '0;
		for (int i = 0; i < MAX_DIMS - 1; i++) begin
			if ((AXW'(i) < nm1) && (b[i] != blast)) begin
				found = 1'b1;
				lf = AXW'(i);
			end
		end
		l_raw = found ? lf : nm1;

		vn = un;
		if (found && !blast)
			vn[lf] = ~vn[lf];
		if (found || blast)
			vn[nm1] = ~vn[nm1];

		// swap entry 0 with the current axis
		us = un;
		us[0] = un[it_q];
		us[it_q] = un[0];
		vs = vn;
		vs[0] = vn[it_q];
		vs[it_q] = vn[0];

		if (l_raw == '0)
			l_adj = it_q;
		else if (l_raw == it_q)
			l_adj = '0;
		else
			l_adj = l_raw;

		// d set means this level adds +step on that axis
		d = ~(us ^ wn_q);
		wn_nxt = wn_q ^ ~vs;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (n_sat == NW'(1) || m_sat == '0)
							state_q <= ST_HOLD;
						else
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_lvl)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (ho_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath; an exact one reads as all ones from the first digit on
	always_ff @(posedge clk) begin
		if (accept) begin
			frac_q   <= pos_ch.position_is_one ? '1 : pos_ch.position;
			one_q    <= pos_ch.position_is_one;
			n_q      <= n_sat;
			m_q      <= m_sat;
			j_q      <= '0;
			it_q     <= '0;
			wn_q     <= '0;
			signs_q  <= '0;
			direct_q <= direct_d;
		end else if (state_q == ST_RUN) begin
			frac_q <= frac_nxt;
			j_q    <= j_q + LW'(1);
			it_q   <= l_adj;
			wn_q   <= wn_nxt;
			for (int i = 0; i < MAX_DIMS; i++)
				signs_q[i][TOP_BIT - j_q] <= d[i];
		end
	end

	assign ho.valid   = (state_q == ST_HOLD);
	assign ho.single  = (n_q == NW'(1));
	assign ho.direct  = direct_q;
	assign n_out      = n_q;
	assign m_out      = m_q;
	assign signs_out  = signs_q;

endmodule

// File: src/hip_emit.sv
// Output stage: holds the sign words of one point and shifts out one axis
// per cycle while taken, turning each word into a rounded coordinate.
module hip_emit import hip_pkg::*; #(
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hip_ho_t                                ho,
	output logic                                   ho_ready,
	input  logic [$clog2(MAX_DIMS+1)-1:0]          n_in,
	input  logic [$clog2(MAX_LEVELS+1)-1:0]        m_in,
	input  logic [MAX_DIMS-1:0][MAX_LEVELS-1:0]    signs_in,
	hip_out_if.source                              crd
);

	localparam int NW = $clog2(MAX_DIMS + 1);
	localparam int MW = $clog2(MAX_LEVELS + 1);
	localparam logic [ACC_W-1:0] BIAS = ACC_W'(1) << (ACC_FRAC - 1);
	localparam logic [ACC_W-1:0] RND  = ACC_W'(1) << (COORD_FRAC - 1);

	logic [MAX_DIMS-1:0][MAX_LEVELS-1:0] words_q;
	logic [NW-1:0]                       rem_q;
	logic [AXIS_W-1:0]                   axis_q;
	logic [MW-1:0]                       m_q;
	logic                                single_q;
	logic [COORD_W-1:0]                  direct_q;
	logic                                out_valid_q;
	logic [AXIS_W-1:0]                   axis_out_q;
	logic [COORD_W-1:0]                  coord_q;
	logic                                last_q;

	logic                                slot_free;
	logic                                advance;
	logic                                load;
	logic [ACC_W-1:0]                    term;
	logic [ACC_W-1:0]                    sum;
	logic [COORD_W-1:0]                  coord_d;

	assign slot_free = !out_valid_q || crd.ready;
	assign advance   = (rem_q != '0) && slot_free;
	assign ho_ready  = (rem_q == '0) && slot_free;
	assign load      = ho.valid && ho_ready;

	// sum of +-2^-(j+2): 2*D - 2^33 + 2^(33-m), then round half up
	always_comb begin
		term = {2'b00, words_q[0], {(ACC_FRAC - MAX_LEVELS){1'b0}}};
		sum  = term - BIAS + (BIAS >> m_q) + RND;
		coord_d = single_q ? direct_q : sum[COORD_FRAC +: COORD_W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (crd.ready)
				out_valid_q <= 1'b0;
			if (load)
				rem_q <= n_in;
			else if (advance)
				rem_q <= rem_q - NW'(1);
		end
	end

	// word shift register and output register
	always_ff @(posedge clk) begin
		if (load) begin
			words_q  <= signs_in;
			axis_q   <= '0;
			m_q      <= m_in;
			single_q <= ho.single;
			direct_q <= ho.direct;
		end else if (advance) begin
			words_q    <= {MAX_LEVELS'(0), words_q[MAX_DIMS-1:1]};
			axis_q     <= axis_q + AXIS_W'(1);
			axis_out_q <= axis_q;
			coord_q    <= coord_d;
			last_q     <= (rem_q == NW'(1));
		end
	end

	assign crd.valid = out_valid_q;
	assign crd.axis  = axis_out_q;
	assign crd.coord = $signed(coord_q);
	assign crd.last  = last_q;

endmodule

// File: src/hilbert_index_to_point.sv
// Flow: an accepted position runs through the level engine, one digit per cycle
//   (skipped for one dimension or zero levels), then is handed to the output
//   stage, which offers one coordinate per cycle while taken. A new position
//   can be accepted while the output stage still shifts out the previous point.
// Reset: arst_n low clears all handshake state, dims to 2 and levels to 10.
module hilbert_index_to_point import hip_pkg::*; #(
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hip_in_if.sink               pos_ch,
	hip_out_if.source            crd_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [DIMS_W-1:0]                   dims_q;
	logic [LEVELS_W-1:0]                 levels_q;
	hip_ho_t                             ho;
	logic                                ho_ready;
	logic [$clog2(MAX_DIMS+1)-1:0]       n_hand;
	logic [$clog2(MAX_LEVELS+1)-1:0]     m_hand;
	logic [MAX_DIMS-1:0][MAX_LEVELS-1:0] signs_hand;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q   <= DIMS_RESET;
			levels_q <= LEVELS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIMS:   dims_q   <= cfg_data[DIMS_W-1:0];
				CFG_LEVELS: levels_q <= cfg_data[LEVELS_W-1:0];
				default: ;
			endcase
		end
	end

	hip_core #(
		.MAX_DIMS   (MAX_DIMS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_ch    (pos_ch),
		.dims      (dims_q),
		.levels    (levels_q),
		.ho        (ho),
		.ho_ready  (ho_ready),
		.n_out     (n_hand),
		.m_out     (m_hand),
		.signs_out (signs_hand)
	);

	hip_emit #(
		.MAX_DIMS   (MAX_DIMS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ho       (ho),
		.ho_ready (ho_ready),
		.n_in     (n_hand),
		.m_in     (m_hand),
		.signs_in (signs_hand),
		.crd      (crd_ch)
	);

endmodule

// File: src/hip_checker.sv
`include "assert_macros.svh"

// Port-level checks: output stalls, axis order and point bookkeeping.
module hip_checker import hip_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [AXIS_W-1:0]         out_axis,
	input logic signed [COORD_W-1:0] out_coord,
	input logic                      out_last
);

	logic [AXIS_W-1:0] exp_axis_q;
	logic [1:0]        pend_q;
	logic              in_acc;
	logic              out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// expected axis and points accepted but not fully delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_axis_q <= '0;
			pend_q     <= '0;
		end else begin
			if (out_acc)
				exp_axis_q <= out_last ? '0 : exp_axis_q + AXIS_W'(1);
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc && out_last);
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_axis) && $stable(out_coord) && $stable(out_last), "stalled output item changed")
	`ASSERT_IMPL(a_axis_order, clk, arst_n, out_valid, out_axis == exp_axis_q, "axis out of order")
	`ASSERT_IMPL(a_no_orphan, clk, arst_n, out_valid, pend_q != 2'd0, "output item without a point")
	`ASSERT_IMPL(a_pend_bound, clk, arst_n, in_acc, pend_q < 2'd2, "too many points in flight")

endmodule

bind hilbert_index_to_point hip_checker u_hip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pos_ch.valid),
	.in_ready  (pos_ch.ready),
	.out_valid (crd_ch.valid),
	.out_ready (crd_ch.ready),
	.out_axis  (crd_ch.axis),
	.out_coord (crd_ch.coord),
	.out_last  (crd_ch.last)
);
